>>> rtl/core/rac_pkg.sv
package rac_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int SUM_NUM_W = 33;
    localparam int SUM_DEN_W = 31;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_RED   = 10'b0000000010,
        ST_GCD   = 10'b0000000100,
        ST_DIV   = 10'b0000001000,
        ST_NEXT  = 10'b0000010000,
        ST_MUL   = 10'b0000100000,
        ST_SUM   = 10'b0001000000,
        ST_SETUP = 10'b0010000000,
        ST_DONE  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;
endpackage

>>> rtl/core/rational_add_reduce_compare.sv
// Rational adder: reduces a/b and c/d to lowest terms, returns the reduced sum
// with a positive denominator plus equal and less-than flags of the operands.
// One item at a time; s_ready is high only when idle. All gcd and exact-division
// work runs on one shared subtract/shift unit: each remainder step is restoring
// division, one quotient bit per cycle over the 2*OPERAND_WIDTH+1 bit value width.
// Each Euclid step is one such division, and dividing out the gcd takes two more,
// for the numerator, then the denominator. There are three reduced pairs per item
// (both operands, then the sum), plus loading, the three products and the sum.
// A zero denominator presents its result in the cycle after the input transfer.
module rational_add_reduce_compare
    import rac_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [OPERAND_WIDTH-1:0] s_first_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_first_den,
    input  logic signed [OPERAND_WIDTH-1:0] s_second_num,
    input  logic signed [OPERAND_WIDTH-1:0] s_second_den,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SUM_NUM_W-1:0]   m_sum_num,
    output logic        [SUM_DEN_W-1:0]   m_sum_den,
    output logic                          m_is_equal,
    output logic                          m_is_less,
    output logic                          m_zero_den_error
);
    // magnitude widths: operand, product, sum
    localparam int MW = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int VW = PW + 1;
    localparam int CW = $clog2(VW + 1);

    state_t state_reg;
    logic [1:0] pair_reg;       // 0 first, 1 second, 2 sum
    logic [VW-1:0] x_reg, y_reg;     // euclid pair
    logic [VW-1:0] n_reg, d_reg;     // current magnitudes
    logic [VW-1:0] g_reg;
    logic [VW-1:0] rem_reg, quo_reg, dvd_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0] dsel_reg;       // 0 gcd remainder, 1 divide n, 2 divide d
    logic neg_reg;
    logic [MW:0] an_reg, ad_reg, cn_reg, cd_reg;
    logic an_neg_reg, cn_neg_reg;
    logic signed [SUM_NUM_W-1:0] sum_num_reg;
    logic [SUM_DEN_W-1:0] sum_den_reg;
    logic eq_reg, lt_reg, err_reg;
    logic signed [OPERAND_WIDTH-1:0] in_a_reg, in_b_reg, in_c_reg, in_d_reg;
    logic [PW-1:0] m1_reg, m2_reg;
    logic [PW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;

    // shared subtractor of the restoring divider
    logic [VW-1:0] trial;
    logic [VW:0] diff;
    assign trial = {rem_reg[VW-2:0], dvd_reg[VW-1]};
    assign diff = {1'b0, trial} - {1'b0, dvs_reg};

    // one multiplier, used for both cross products and the denominator product
    assign mul_p = mul_a * mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cnt_reg[1:0])
            2'd0: begin mul_a = PW'(an_reg); mul_b = PW'(cd_reg); end
            2'd1: begin mul_a = PW'(cn_reg); mul_b = PW'(ad_reg); end
            default: begin mul_a = PW'(ad_reg); mul_b = PW'(cd_reg); end
        endcase
    end

    function automatic logic [MW:0] mag_f(input logic signed [OPERAND_WIDTH-1:0] v);
        logic [MW:0] e;
        e = {v[OPERAND_WIDTH-1], v};
        return v[OPERAND_WIDTH-1] ? (MW+1)'(~e + 1'b1) : e;
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_sum_num = sum_num_reg;
    assign m_sum_den = sum_den_reg;
    assign m_is_equal = eq_reg;
    assign m_is_less = lt_reg;
    assign m_zero_den_error = err_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_a_reg <= s_first_num;
                        in_b_reg <= s_first_den;
                        in_c_reg <= s_second_num;
                        in_d_reg <= s_second_den;
                        pair_reg <= 2'd0;
                        if (s_first_den == '0 || s_second_den == '0) begin
                            err_reg <= 1'b1;
                            sum_num_reg <= '0;
                            sum_den_reg <= SUM_DEN_W'(1);
                            eq_reg <= 1'b0;
                            lt_reg <= 1'b0;
                            state_reg <= ST_OUT;
                        end else begin
                            err_reg <= 1'b0;
                            state_reg <= ST_RED;
                        end
                    end
                end
                // load a pair for reduction
                ST_RED: begin
                    if (pair_reg == 2'd0) begin
                        n_reg <= VW'(mag_f(in_a_reg));
                        d_reg <= VW'(mag_f(in_b_reg));
                        neg_reg <= in_a_reg[OPERAND_WIDTH-1] ^ in_b_reg[OPERAND_WIDTH-1];
                        x_reg <= VW'(mag_f(in_a_reg));
                        y_reg <= VW'(mag_f(in_b_reg));
                    end else begin
                        n_reg <= VW'(mag_f(in_c_reg));
                        d_reg <= VW'(mag_f(in_d_reg));
                        neg_reg <= in_c_reg[OPERAND_WIDTH-1] ^ in_d_reg[OPERAND_WIDTH-1];
                        x_reg <= VW'(mag_f(in_c_reg));
                        y_reg <= VW'(mag_f(in_d_reg));
                    end
                    state_reg <= ST_GCD;
                end
                // euclid: start x mod y, or finish
                ST_GCD: begin
                    if (y_reg == '0) begin
                        g_reg <= (x_reg == '0) ? VW'(1) : x_reg;
                        dvd_reg <= n_reg;
                        dvs_reg <= (x_reg == '0) ? VW'(1) : x_reg;
                        dsel_reg <= 2'd1;
                    end else begin
                        dvd_reg <= x_reg;
                        dvs_reg <= y_reg;
                        dsel_reg <= 2'd0;
                    end
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= CW'(VW);
                    state_reg <= ST_DIV;
                end
                // one quotient bit per cycle
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_NEXT;
                    end else begin
                        dvd_reg <= {dvd_reg[VW-2:0], 1'b0};
                        if (!diff[VW]) begin
                            rem_reg <= diff[VW-1:0];
                            quo_reg <= {quo_reg[VW-2:0], 1'b1};
                        end else begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[VW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_NEXT: begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    unique case (dsel_reg)
                        2'd0: begin
                            x_reg <= y_reg;
                            y_reg <= rem_reg;
                            cnt_reg <= CW'(VW);
                            state_reg <= ST_GCD;
                        end
                        2'd1: begin
                            n_reg <= quo_reg;
                            dvd_reg <= d_reg;
                            dvs_reg <= g_reg;
                            dsel_reg <= 2'd2;
                            cnt_reg <= CW'(VW);
                            state_reg <= ST_DIV;
                        end
                        default: begin
                            d_reg <= quo_reg;
                            cnt_reg <= '0;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                // store a reduced pair
                ST_DONE: begin
                    unique case (pair_reg)
                        2'd0: begin
                            an_reg <= (MW+1)'(n_reg);
                            ad_reg <= (MW+1)'(d_reg);
                            an_neg_reg <= neg_reg && (n_reg != '0);
                            pair_reg <= 2'd1;
                            state_reg <= ST_RED;
                        end
                        2'd1: begin
                            cn_reg <= (MW+1)'(n_reg);
                            cd_reg <= (MW+1)'(d_reg);
                            cn_neg_reg <= neg_reg && (n_reg != '0);
                            pair_reg <= 2'd2;
                            cnt_reg <= '0;
                            state_reg <= ST_MUL;
                        end
                        default: begin
                            sum_num_reg <= (neg_reg && n_reg != '0) ?
                                SUM_NUM_W'(~n_reg + 1'b1) : SUM_NUM_W'(n_reg);
                            sum_den_reg <= SUM_DEN_W'(d_reg);
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                // three products through the one multiplier
                ST_MUL: begin
                    unique case (cnt_reg[1:0])
                        2'd0: m1_reg <= mul_p;
                        2'd1: m2_reg <= mul_p;
                        default: begin
                            d_reg <= VW'(mul_p);
                            y_reg <= VW'(mul_p);
                        end
                    endcase
                    eq_reg <= (an_reg == cn_reg) && (ad_reg == cd_reg)
                              && (an_neg_reg == cn_neg_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[1:0] == 2'd2) state_reg <= ST_SUM;
                end
                // signed sum in sign-magnitude form and compare
                ST_SUM: begin
                    if (an_neg_reg == cn_neg_reg) begin
                        n_reg <= VW'(m1_reg) + VW'(m2_reg);
                        x_reg <= VW'(m1_reg) + VW'(m2_reg);
                        neg_reg <= an_neg_reg;
                    end else if (m1_reg >= m2_reg) begin
                        n_reg <= VW'(m1_reg - m2_reg);
                        x_reg <= VW'(m1_reg - m2_reg);
                        neg_reg <= an_neg_reg;
                    end else begin
                        n_reg <= VW'(m2_reg - m1_reg);
                        x_reg <= VW'(m2_reg - m1_reg);
                        neg_reg <= cn_neg_reg;
                    end
                    if (an_neg_reg != cn_neg_reg) begin
                        lt_reg <= an_neg_reg && ((m1_reg != '0) || (m2_reg != '0));
                    end else if (an_neg_reg) begin
                        lt_reg <= m1_reg > m2_reg;
                    end else begin
                        lt_reg <= m1_reg < m2_reg;
                    end
                    state_reg <= ST_SETUP;
                end
                ST_SETUP: begin
                    state_reg <= ST_GCD;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> sim/tb.sv
module tb;
    import rac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = OPERAND_WIDTH_DEF;
    localparam int N_RANDOM = 530;
    localparam int STALL_LONG = 3000;

    typedef struct packed {
        logic signed [SUM_NUM_W-1:0] sum_num;
        logic        [SUM_DEN_W-1:0] sum_den;
        logic                        is_equal;
        logic                        is_less;
        logic                        zero_den_error;
    } sum_result_t;

    typedef struct {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic signed [W-1:0] d;
        bit                  has_known;
        sum_result_t         known;
    } fraction_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [W-1:0] s_first_num;
    logic signed [W-1:0] s_first_den;
    logic signed [W-1:0] s_second_num;
    logic signed [W-1:0] s_second_den;
    logic m_valid;
    logic m_ready;
    logic signed [SUM_NUM_W-1:0] m_sum_num;
    logic [SUM_DEN_W-1:0] m_sum_den;
    logic m_is_equal;
    logic m_is_less;
    logic m_zero_den_error;

    sum_result_t pending_sums[$];
    int mismatches;
    int sums_seen;
    int zero_den_seen;
    bit quiet_tail;
    bit hold_sink;

    rational_add_reduce_compare u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_num     (s_first_num),
        .s_first_den     (s_first_den),
        .s_second_num    (s_second_num),
        .s_second_den    (s_second_den),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sum_num       (m_sum_num),
        .m_sum_den       (m_sum_den),
        .m_is_equal      (m_is_equal),
        .m_is_less       (m_is_less),
        .m_zero_den_error(m_zero_den_error)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return (x == 0) ? 1 : x;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // lowest terms with positive denominator
    function automatic void lowest_terms(input longint n, input longint d,
                                         output longint rn, output longint rd);
        bit neg;
        longint unsigned mn, md, g;
        neg = (n < 0) != (d < 0);
        mn = magnitude(n);
        md = magnitude(d);
        g = euclid_gcd(mn, md);
        mn = mn / g;
        md = md / g;
        if (mn == 0) neg = 1'b0;
        rn = neg ? -longint'(mn) : longint'(mn);
        rd = longint'(md);
    endfunction

    function automatic sum_result_t rational_sum(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                                 logic signed [W-1:0] c, logic signed [W-1:0] d);
        sum_result_t r;
        longint an, ad, cn, cd, p1, p2;
        longint unsigned m1, m2, smag, sden, g;
        bit sneg;
        r = '0;
        r.sum_den = 1;
        if (b == 0 || d == 0) begin
            r.zero_den_error = 1'b1;
            return r;
        end
        lowest_terms(longint'(a), longint'(b), an, ad);
        lowest_terms(longint'(c), longint'(d), cn, cd);
        p1 = an * cd;
        p2 = cn * ad;
        m1 = magnitude(p1);
        m2 = magnitude(p2);
        if ((p1 < 0) == (p2 < 0)) begin
            smag = m1 + m2;
            sneg = p1 < 0;
        end else if (m1 >= m2) begin
            smag = m1 - m2;
            sneg = p1 < 0;
        end else begin
            smag = m2 - m1;
            sneg = p2 < 0;
        end
        sden = ad * cd;
        g = euclid_gcd(smag, sden);
        smag = smag / g;
        sden = sden / g;
        if (smag == 0) sneg = 1'b0;
        r.sum_num = sneg ? SUM_NUM_W'(-smag) : SUM_NUM_W'(smag);
        r.sum_den = SUM_DEN_W'(sden);
        r.is_equal = (an == cn) && (ad == cd);
        r.is_less = p1 < p2;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on sum %0d: %s got %0d want %0d", sums_seen, what, got, want);
        mismatches++;
    endtask

    // random operand: biased toward small values, extremes and zero
    function automatic logic signed [W-1:0] pick_operand(bit nonzero);
        logic signed [W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = -16'sd32768;
            1: v = 16'sd32767;
            2: v = '0;
            3, 4, 5: v = W'($urandom_range(0, 40) - 20);
            6, 7: v = W'($urandom_range(0, 1000) - 500);
            default: v = W'($urandom);
        endcase
        if (nonzero && v == 0) v = 16'sd1;
        return v;
    endfunction

    // reset, then hold inputs quiet
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_first_num = '0;
        s_first_den = '0;
        s_second_num = '0;
        s_second_den = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // result sink with random stalls
    initial begin
        int burst;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // long receiver hold-off, counted here
    initial begin
        hold_sink = 1'b0;
        @(posedge aclk iff aresetn);
        repeat (400) @(posedge aclk);
        hold_sink = 1'b1;
        repeat (STALL_LONG) @(posedge aclk);
        hold_sink = 1'b0;
    end

    // compare each result transfer with the oldest expected sum
    always @(posedge aclk) begin
        sum_result_t want;
        if (aresetn && m_valid && m_ready) begin
            sums_seen++;
            if (pending_sums.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = pending_sums.pop_front();
                if (m_zero_den_error) zero_den_seen++;
                if (m_sum_num !== want.sum_num)
                    report_mismatch("sum_num", m_sum_num, want.sum_num);
                if (m_sum_den !== want.sum_den)
                    report_mismatch("sum_den", m_sum_den, want.sum_den);
                if (m_is_equal !== want.is_equal)
                    report_mismatch("is_equal", m_is_equal, want.is_equal);
                if (m_is_less !== want.is_less)
                    report_mismatch("is_less", m_is_less, want.is_less);
                if (m_zero_den_error !== want.zero_den_error)
                    report_mismatch("zero_den_error", m_zero_den_error, want.zero_den_error);
            end
        end
    end

    // valid stays high between back-to-back offers, drops only for idling
    task automatic offer_fractions(logic signed [W-1:0] a, logic signed [W-1:0] b,
                                   logic signed [W-1:0] c, logic signed [W-1:0] d,
                                   bit has_known, sum_result_t known);
        sum_result_t want;
        want = rational_sum(a, b, c, d);
        if (has_known && want !== known) begin
            $display("directed row disagrees with predictor: %0d/%0d + %0d/%0d", a, b, c, d);
            mismatches++;
        end
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_first_num <= a;
        s_first_den <= b;
        s_second_num <= c;
        s_second_den <= d;
        @(posedge aclk iff s_ready);
        pending_sums.insert(pending_sums.size(), has_known ? known : want);
    endtask

    function automatic sum_result_t known_sum(longint n, longint d, bit eq, bit lt, bit err);
        sum_result_t r;
        r.sum_num = SUM_NUM_W'(n);
        r.sum_den = SUM_DEN_W'(d);
        r.is_equal = eq;
        r.is_less = lt;
        r.zero_den_error = err;
        return r;
    endfunction

    // stimulus
    initial begin
        fraction_row_t rows[$];
        sum_result_t none;
        logic signed [W-1:0] a, b, c, d;
        int k;
        none = '0;
        mismatches = 0;
        sums_seen = 0;
        zero_den_seen = 0;
        quiet_tail = 1'b0;
        rows = '{
            '{16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, known_sum(5, 6, 0, 0, 0)},
            '{16'sd0, 16'sd5, 16'sd0, -16'sd7, 1'b1, known_sum(0, 1, 1, 0, 0)},
            '{16'sd3, 16'sd0, 16'sd1, 16'sd1, 1'b1, known_sum(0, 1, 0, 0, 1)},
            '{16'sd1, 16'sd1, 16'sd3, 16'sd0, 1'b1, known_sum(0, 1, 0, 0, 1)},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, known_sum(0, 1, 0, 0, 1)},
            '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 1'b1, known_sum(32768, 1, 0, 0, 0)},
            '{-16'sd32768, 16'sd1, -16'sd32768, 16'sd1, 1'b1,
              known_sum(-65536, 1, 1, 0, 0)},
            '{16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 1'b1, known_sum(65534, 1, 1, 0, 0)},
            '{16'sd2, 16'sd4, -16'sd1, -16'sd2, 1'b1, known_sum(1, 1, 1, 0, 0)},
            '{-16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, known_sum(0, 1, 0, 1, 0)},
            '{16'sd1, -16'sd32768, 16'sd1, 16'sd32767, 1'b0, none},
            '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, none},
            '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, none},
            '{16'sd12, -16'sd18, 16'sd5, 16'sd15, 1'b0, none},
            '{16'sd32767, 16'sd32766, 16'sd32765, 16'sd32764, 1'b0, none},
            '{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 1'b0, none},
            '{-16'sd32768, 16'sd32767, 16'sd1, 16'sd32767, 1'b0, none}
        };
        @(posedge aclk iff aresetn);
        foreach (rows[i])
            offer_fractions(rows[i].a, rows[i].b, rows[i].c, rows[i].d,
                            rows[i].has_known, rows[i].known);
        s_valid <= 1'b0;
        // sender pause until everything has drained
        wait (pending_sums.size() == 0);
        @(posedge aclk);
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 60) quiet_tail = 1'b1;
            a = pick_operand(1'b0);
            b = ($urandom_range(0, 19) == 0) ? 16'sd0 : pick_operand(1'b1);
            c = pick_operand(1'b0);
            d = ($urandom_range(0, 19) == 0) ? 16'sd0 : pick_operand(1'b1);
            if ($urandom_range(0, 9) == 0) begin
                // equal value, scaled differently (unless doubling overflows)
                c = W'(a * 2);
                d = W'(b * 2);
            end
            offer_fractions(a, b, c, d, 1'b0, none);
        end
        s_valid <= 1'b0;
        wait (pending_sums.size() == 0);
        repeat (50) @(posedge aclk);
        $display("covered %0d sums, %0d with a zero denominator, including extremes",
                 sums_seen, zero_den_seen);
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // overall limit
    initial begin
        #20000000;
        $display("timeout with %0d sums outstanding", pending_sums.size());
        $display("status: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/rac_pkg.sv
rtl/core/rational_add_reduce_compare.sv
sim/tb.sv
